### hw/rtl/ssi_pkg.sv
// Shared types and constants for the sorted set search/insert core.
// Used by ssi_cmp and sorted_set_search_insert_core; depends on nothing.
package ssi_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FLOOR  = 2'd2;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_NO_FLOOR  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic go_right;
    logic equal;
  } cmp_res_t;

endpackage

### hw/rtl/ssi_cmp.sv
// Shared key comparator for the binary search probes.
// Depends on ssi_pkg.
module ssi_cmp (
  input  logic [ssi_pkg::KEY_W-1:0] probe,
  input  logic [ssi_pkg::KEY_W-1:0] key,
  input  logic                      upper,
  output ssi_pkg::cmp_res_t         res
);

  logic [ssi_pkg::KEY_W-1:0] op_a;
  logic [ssi_pkg::KEY_W-1:0] op_b;
  logic                      lt;

  assign op_a = upper ? key : probe;
  assign op_b = upper ? probe : key;
  assign lt   = $signed(op_a) < $signed(op_b);

  assign res.go_right = upper ? !lt : lt;
  assign res.equal    = (probe == key);

endmodule

### hw/rtl/sorted_set_search_insert_core.sv
// Sorted set of distinct signed keys: binary search, insert, exact search, floor.
// A search or floor result comes after p probes (at most 7), each probe one registered memory
// read plus one pass through the shared comparator; an insert that succeeds then moves m larger
// entries up one place, each through a read state and a write state. One word at a time: a new
// word is taken only once the previous result is in the output register. Reset (rst, synchronous):
// empties the set, drops any pending result.
module sorted_set_search_insert_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ssi_pkg::IN_W-1:0]  s_tdata,  // mode[1:0], key[33:2], zero pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ssi_pkg::OUT_W-1:0] m_tdata   // status[2:0], position[8:3], count[15:9]
);

  ssi_pkg::state_t   state, state_next;
  ssi_pkg::cmp_res_t cmp;
  ssi_pkg::status_t  res_status, out_status;

  logic [ssi_pkg::KEY_W-1:0] mem [ssi_pkg::CAPACITY];
  logic [ssi_pkg::KEY_W-1:0] rdata;
  logic [ssi_pkg::IDX_W-1:0] rd_addr;
  logic                      wr_en;
  logic [ssi_pkg::IDX_W-1:0] wr_addr;
  logic [ssi_pkg::KEY_W-1:0] wr_data;

  logic [1:0]                mode;
  logic [ssi_pkg::KEY_W-1:0] key;
  logic [ssi_pkg::CNT_W-1:0] fill, lo, hi, idx, mid;
  logic [ssi_pkg::CNT_W:0]   mid_sum;
  logic                      hit;
  logic [ssi_pkg::IDX_W-1:0] res_pos, out_pos;
  logic [ssi_pkg::CNT_W-1:0] out_count;
  logic                      is_insert, is_floor, ins_ok, out_free, searching;
  logic [ssi_pkg::CNT_W-1:0] idx_dec;

  function automatic logic [ssi_pkg::IDX_W-1:0] idx_of_floor(
    input logic [ssi_pkg::CNT_W-1:0] ub
  );
    logic [ssi_pkg::CNT_W-1:0] p;
    p = ub - ssi_pkg::CNT_W'(1);
    return p[ssi_pkg::IDX_W-1:0];
  endfunction

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[ssi_pkg::CNT_W:1];
  assign is_insert = (mode == ssi_pkg::MODE_INSERT);
  assign is_floor  = (mode == ssi_pkg::MODE_FLOOR);
  assign ins_ok    = is_insert && !hit && (fill != ssi_pkg::CNT_W'(ssi_pkg::CAPACITY));
  assign out_free  = !m_tvalid || m_tready;
  assign searching = (lo < hi);
  assign idx_dec   = idx - ssi_pkg::CNT_W'(1);

  ssi_cmp u_cmp (
    .probe (rdata),
    .key   (key),
    .upper (is_floor),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssi_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = ssi_pkg::ST_PROBE;
      end
      ssi_pkg::ST_PROBE: begin
        if (searching) state_next = ssi_pkg::ST_CMP;
        else if (!ins_ok) state_next = ssi_pkg::ST_DONE;
        else if (fill > lo) state_next = ssi_pkg::ST_SHIFT_RD;
        else state_next = ssi_pkg::ST_PLACE;
      end
      ssi_pkg::ST_CMP: state_next = ssi_pkg::ST_PROBE;
      ssi_pkg::ST_SHIFT_RD: state_next = ssi_pkg::ST_SHIFT_WR;
      ssi_pkg::ST_SHIFT_WR: begin
        if (idx_dec > lo) state_next = ssi_pkg::ST_SHIFT_RD;
        else state_next = ssi_pkg::ST_PLACE;
      end
      ssi_pkg::ST_PLACE: state_next = ssi_pkg::ST_DONE;
      ssi_pkg::ST_DONE: begin
        if (out_free) state_next = ssi_pkg::ST_IDLE;
      end
      default: state_next = ssi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_addr  = mid[ssi_pkg::IDX_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = idx[ssi_pkg::IDX_W-1:0];
    wr_data  = rdata;
    unique case (state)
      ssi_pkg::ST_IDLE: s_tready = 1'b1;
      ssi_pkg::ST_SHIFT_RD: rd_addr = idx_dec[ssi_pkg::IDX_W-1:0];
      ssi_pkg::ST_SHIFT_WR: wr_en = 1'b1;
      ssi_pkg::ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = lo[ssi_pkg::IDX_W-1:0];
        wr_data = key;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssi_pkg::ST_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready && !(state == ssi_pkg::ST_DONE && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ssi_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            mode <= s_tdata[1:0];
            key  <= s_tdata[33:2];
            lo   <= '0;
            hi   <= fill;
            hit  <= 1'b0;
          end
        end
        ssi_pkg::ST_CMP: begin
          if (cmp.go_right) begin
            lo <= mid + ssi_pkg::CNT_W'(1);
          end else begin
            hi  <= mid;
            hit <= cmp.equal;
          end
        end
        ssi_pkg::ST_PROBE: begin
          if (!searching) begin
            idx     <= fill;
            res_pos <= '0;
            if (is_insert) begin
              if (hit) begin
                res_status <= ssi_pkg::STAT_DUPLICATE;
              end else if (!ins_ok) begin
                res_status <= ssi_pkg::STAT_FULL;
              end else begin
                res_status <= ssi_pkg::STAT_INSERTED;
                res_pos    <= lo[ssi_pkg::IDX_W-1:0];
              end
            end else if (is_floor) begin
              if (lo == '0) begin
                res_status <= ssi_pkg::STAT_NO_FLOOR;
              end else begin
                res_status <= ssi_pkg::STAT_FOUND;
                res_pos    <= idx_of_floor(lo);
              end
            end else if (hit) begin
              res_status <= ssi_pkg::STAT_FOUND;
              res_pos    <= lo[ssi_pkg::IDX_W-1:0];
            end else begin
              res_status <= ssi_pkg::STAT_NOT_FOUND;
            end
          end
        end
        ssi_pkg::ST_SHIFT_WR: idx <= idx_dec;
        ssi_pkg::ST_PLACE: fill <= fill + ssi_pkg::CNT_W'(1);
        ssi_pkg::ST_DONE: begin
          if (out_free) begin
            out_status <= res_status;
            out_pos    <= res_pos;
            out_count  <= fill;
            m_tvalid   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {out_count, out_pos, out_status};

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= ssi_pkg::CNT_W'(ssi_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_fill_only_place: assert property (@(posedge clk) disable iff (rst)
    (state != ssi_pkg::ST_PLACE) |=> $stable(fill))
    else $error("fill count changed outside placement");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (state != ssi_pkg::ST_IDLE) |-> (lo <= hi && hi <= fill))
    else $error("search bounds out of order");

  a_insert_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ssi_pkg::STAT_INSERTED) |->
      ({1'b0, out_pos} < out_count))
    else $error("inserted position beyond count");

endmodule

### bench/sorted_set_search_insert_core_tb.sv
// Self-checking bench for sorted_set_search_insert_core: drives insert, search, floor and spare-mode words,
// predicts each result from a local copy of the sorted table and checks every output word.
// Depends on ssi_pkg and the core RTL only.
module sorted_set_search_insert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int RANDOM_WORDS = 1026;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 200;
  localparam int PRINT_CAP    = 100;

  typedef struct {
    logic [1:0]                       mode;
    logic signed [ssi_pkg::KEY_W-1:0] key;
    int                               phase;
    bit                               drain;
  } request_t;

  typedef struct {
    ssi_pkg::status_t          status;
    logic [ssi_pkg::IDX_W-1:0] position;
    logic [ssi_pkg::CNT_W-1:0] count;
  } lookup_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [ssi_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [ssi_pkg::OUT_W-1:0] m_tdata;

  request_t                          pending_words[$];
  lookup_result_t                    result_q[$];
  logic signed [ssi_pkg::KEY_W-1:0]  key_table [ssi_pkg::CAPACITY];
  int                                key_fill = 0;
  logic signed [ssi_pkg::KEY_W-1:0]  inserted_keys[$];
  int                                rx_phase = 0;
  int                                failures = 0;
  int                                printed = 0;
  int                                cycles = 0;
  int                                tx_idle_pct [4] = '{0, 57, 0, 30};
  int                                rx_stall_pct[4] = '{0, 0, 57, 30};

  sorted_set_search_insert_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int key_bound(logic signed [ssi_pkg::KEY_W-1:0] key, bit upper);
    int lo;
    int hi;
    int mid;
    bit go_right;
    lo = 0;
    hi = key_fill;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      go_right = upper ? !(key < key_table[mid]) : (key_table[mid] < key);
      if (go_right) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void predict_request(request_t req);
    lookup_result_t res;
    int at;
    res.position = '0;
    if (req.mode == ssi_pkg::MODE_INSERT) begin
      at = key_bound(req.key, 1'b0);
      if (at < key_fill && key_table[at] == req.key) begin
        res.status = ssi_pkg::STAT_DUPLICATE;
      end else if (key_fill >= ssi_pkg::CAPACITY) begin
        res.status = ssi_pkg::STAT_FULL;
      end else begin
        for (int i = key_fill; i > at; i--) key_table[i] = key_table[i-1];
        key_table[at] = req.key;
        key_fill++;
        res.status = ssi_pkg::STAT_INSERTED;
        res.position = ssi_pkg::IDX_W'(at);
      end
    end else if (req.mode == ssi_pkg::MODE_FLOOR) begin
      at = key_bound(req.key, 1'b1);
      if (at == 0) begin
        res.status = ssi_pkg::STAT_NO_FLOOR;
      end else begin
        res.status = ssi_pkg::STAT_FOUND;
        res.position = ssi_pkg::IDX_W'(at - 1);
      end
    end else begin
      at = key_bound(req.key, 1'b0);
      if (at < key_fill && key_table[at] == req.key) begin
        res.status = ssi_pkg::STAT_FOUND;
        res.position = ssi_pkg::IDX_W'(at);
      end else begin
        res.status = ssi_pkg::STAT_NOT_FOUND;
      end
    end
    res.count = ssi_pkg::CNT_W'(key_fill);
    result_q.push_back(res);
  endfunction

  function automatic void queue_word(logic [1:0] mode, logic signed [ssi_pkg::KEY_W-1:0] key,
                                     int phase, bit drain);
    request_t req;
    req.mode = mode;
    req.key = key;
    req.phase = phase;
    req.drain = drain;
    pending_words.push_back(req);
  endfunction

  function automatic logic signed [ssi_pkg::KEY_W-1:0] pick_key();
    int r;
    logic signed [ssi_pkg::KEY_W-1:0] k;
    r = $urandom_range(99);
    if (inserted_keys.size() > 0 && r < 40) begin
      k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
    end else if (inserted_keys.size() > 0 && r < 65) begin
      k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      k = $urandom_range(1) ? k + 1 : k - 1;
    end else if (r < 70) begin
      case ($urandom_range(3))
        0: k = 32'sh8000_0000;
        1: k = 32'sh7fff_ffff;
        2: k = 32'sh0000_0000;
        default: k = -32'sd1;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  always @(posedge clk) begin : driver
    bit fire;
    bit hold;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        rx_phase = pending_words[0].phase;
        predict_request(pending_words[0]);
        void'(pending_words.pop_front());
      end
      if (!s_tvalid || fire) begin
        hold = 1'b1;
        if (pending_words.size() > 0) begin
          hold = (pending_words[0].drain && result_q.size() > 0) ||
                 ($urandom_range(99) < tx_idle_pct[pending_words[0].phase]);
        end
        if (hold) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= {{(ssi_pkg::IN_W-ssi_pkg::KEY_W-2){1'b0}}, pending_words[0].key,
                       pending_words[0].mode};
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    lookup_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          failures++;
          if (printed < PRINT_CAP) begin
            printed++;
            $display("%0t: unexpected word: status %0d position %0d count %0d",
                     $time, m_tdata[2:0], m_tdata[8:3], m_tdata[15:9]);
          end
        end else begin
          want = result_q.pop_front();
          if (m_tdata[2:0] !== want.status || m_tdata[8:3] !== want.position ||
              m_tdata[15:9] !== want.count) begin
            failures++;
            if (printed < PRINT_CAP) begin
              printed++;
              $display({"%0t: mismatch: expected status %0d position %0d count %0d, ",
                        "got status %0d position %0d count %0d"},
                       $time, want.status, want.position, want.count,
                       m_tdata[2:0], m_tdata[8:3], m_tdata[15:9]);
            end
          end
        end
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct[rx_phase]);
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_set_search_insert_core regression: fail");
      $finish;
    end
  end

  initial begin : sequencer
    int r;
    int ph;
    int last_ph;
    logic [1:0] mode;
    logic signed [ssi_pkg::KEY_W-1:0] k;
    last_ph = 0;

    // empty table, then a few keys around zero and the extremes
    queue_word(MODE_SEARCH, 32'sd0, 0, 1'b0);
    queue_word(ssi_pkg::MODE_FLOOR,  32'sd0, 0, 1'b0);
    queue_word(MODE_SPARE,  32'sd5, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, 32'sd0, 0, 1'b0);
    queue_word(ssi_pkg::MODE_FLOOR,  -32'sd1, 0, 1'b0);
    queue_word(ssi_pkg::MODE_FLOOR,  32'sd0, 0, 1'b0);
    queue_word(MODE_SEARCH, -32'sd1, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, 32'sh8000_0000, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, 32'sh7fff_ffff, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, -32'sd1, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, 32'sd1, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, 32'sd0, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, 32'sh5555_5555, 0, 1'b0);
    queue_word(ssi_pkg::MODE_INSERT, 32'shaaaa_aaaa, 0, 1'b0);
    queue_word(MODE_SEARCH, 32'sh8000_0000, 0, 1'b0);
    queue_word(MODE_SEARCH, 32'sh7fff_ffff, 0, 1'b0);
    queue_word(MODE_SEARCH, 32'sd2, 0, 1'b0);
    queue_word(ssi_pkg::MODE_FLOOR,  32'sh8000_0000, 0, 1'b0);
    queue_word(ssi_pkg::MODE_FLOOR,  32'sh7fff_ffff, 0, 1'b0);
    queue_word(ssi_pkg::MODE_FLOOR,  32'sd100, 0, 1'b0);
    queue_word(ssi_pkg::MODE_FLOOR,  -32'sd5, 0, 1'b0);
    queue_word(MODE_SPARE,  -32'sd1, 0, 1'b0);
    queue_word(MODE_SPARE,  32'sd3, 0, 1'b0);
    foreach (pending_words[i])
      if (pending_words[i].mode == ssi_pkg::MODE_INSERT)
        inserted_keys.push_back(pending_words[i].key);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      ph = (i * 4) / RANDOM_WORDS;
      r = $urandom_range(99);
      if (r < 40) mode = ssi_pkg::MODE_INSERT;
      else if (r < 70) mode = MODE_SEARCH;
      else if (r < 95) mode = ssi_pkg::MODE_FLOOR;
      else mode = MODE_SPARE;
      k = pick_key();
      if (mode == ssi_pkg::MODE_INSERT) inserted_keys.push_back(k);
      queue_word(mode, k, ph, ph != last_ph);
      last_ph = ph;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() > 0 || result_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("sorted_set_search_insert_core regression: pass");
    end else begin
      $display("sorted_set_search_insert_core regression: fail");
    end
    $finish;
  end

endmodule
